@@ rtl/pvs_pkg.sv @@
// Shared types, field layout and codes for the palette voxel store.
// No dependencies; imported by palette_voxel_store_top.
package pvs_pkg;

   localparam int ID_W       = 64;
   localparam int POS_W      = 4;
   localparam int ACT_W      = 2;
   localparam int SLOT_OUT_W = 4;
   localparam int FACE_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int COORD_W    = 10;

   localparam int DEF_EDGE          = 16;
   localparam int DEF_HEIGHT        = 16;
   localparam int DEF_PALETTE_DEPTH = 16;

   // request tdata: pos_x, pos_y, pos_z, block_id, zero pad
   localparam int X_LSB      = 0;
   localparam int Y_LSB      = X_LSB + POS_W;
   localparam int Z_LSB      = Y_LSB + POS_W;
   localparam int ID_LSB     = Z_LSB + POS_W;
   localparam int REQ_DATA_W = ((ID_LSB + ID_W + 7) / 8) * 8;
   localparam int REQ_USER_W = ACT_W;

   // response tdata: read_id, slot, zero pad; tuser: face, status
   localparam int RSP_FILL_W = ID_W + SLOT_OUT_W;
   localparam int RSP_DATA_W = ((RSP_FILL_W + 7) / 8) * 8;
   localparam int RSP_USER_W = FACE_W + STATUS_W;

   typedef logic [ID_W-1:0]           id_type;
   typedef logic signed [COORD_W-1:0] coord_type;

   localparam logic [ACT_W-1:0] ACT_WRITE     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ      = 2'd1;
   localparam logic [ACT_W-1:0] ACT_NEIGHBORS = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR     = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_GRID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd2;

   localparam logic [FACE_W-1:0] FACE_SELF   = 3'd0;
   localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd1;
   localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
   localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd3;
   localparam logic [FACE_W-1:0] FACE_BACK   = 3'd4;
   localparam logic [FACE_W-1:0] FACE_TOP    = 3'd5;
   localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd6;

endpackage

@@ rtl/palette_voxel_store_top.sv @@
// Palette voxel store: voxel slot memory, palette memory and request sequencer.
// Depends on pvs_pkg for field layout, codes and types.
//
// The grid (EDGE x HEIGHT x EDGE) keeps one palette slot per voxel in a
// one-port-read synchronous memory; the palette keeps the 64-bit ids in a
// second memory, with slot zero held in a register. One request is worked on
// at a time and the next is taken once its last response sits in the output
// register. A read does the voxel read followed by the palette read. A
// neighbor read does both for each face inside the grid and neither for a
// face outside it. A write scans the palette one entry per cycle through its
// read port from slot zero up: a hit writes that slot to the voxel, a new id
// is appended and a new id on a full palette is rejected. After reset and
// after each clear a pass zeroes the voxel memory, one entry a cycle, with
// req_tready low; a clear responds when its pass ends. filler_id takes
// effect at the next clear.
module palette_voxel_store_top #(
   parameter int EDGE          = pvs_pkg::DEF_EDGE,
   parameter int HEIGHT        = pvs_pkg::DEF_HEIGHT,
   parameter int PALETTE_DEPTH = pvs_pkg::DEF_PALETTE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pvs_pkg::REQ_DATA_W-1:0] req_tdata,  // pos_x, pos_y, pos_z, block_id
   input  logic [pvs_pkg::REQ_USER_W-1:0] req_tuser,  // action
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pvs_pkg::RSP_DATA_W-1:0] rsp_tdata,  // read_id, slot
   output logic [pvs_pkg::RSP_USER_W-1:0] rsp_tuser,  // face, status
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [pvs_pkg::ID_W-1:0]       csr_wr_data
);
   import pvs_pkg::*;

   localparam int CELLS  = EDGE * EDGE * HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SLOT_W = $clog2(PALETTE_DEPTH);
   localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);

   localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(EDGE);
   localparam logic [ADDR_W-1:0] SLICE_STEP = ADDR_W'(EDGE * HEIGHT);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(PALETTE_DEPTH);
   localparam coord_type         EDGE_C     = coord_type'(EDGE);
   localparam coord_type         HEIGHT_C   = coord_type'(HEIGHT);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_RD_VOX = 3'd2;
   localparam logic [2:0] ST_RD_PAL = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;
   localparam logic [2:0] ST_SWEEP  = 3'd5;

   // memories
   logic [SLOT_W-1:0] vox_mem [CELLS];
   id_type            pal_mem [PALETTE_DEPTH];

   // control state
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  rd_slot_ff, rd_slot_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              clear_pend_ff, clear_pend_in;
   logic [FACE_W-1:0] face_ff, face_in;
   logic              rsp_valid_ff, rsp_valid_in;
   id_type            filler_ff;
   id_type            slot0_ff, slot0_in;

   // payload
   logic [POS_W-1:0]    x_ff, y_ff, z_ff;
   id_type              id_ff;
   logic [ADDR_W-1:0]   cell_ff, cell_in;
   id_type              res_id_ff, res_id_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                use_pal_ff, use_pal_in;
   id_type              rsp_id_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [FACE_W-1:0]   rsp_face_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;
   logic [SLOT_W-1:0]   vox_q_ff;
   id_type              pal_q_ff;

   // memory ports
   logic              vox_we, vox_re;
   logic [ADDR_W-1:0] vox_waddr, vox_raddr;
   logic [SLOT_W-1:0] vox_wdata;
   logic              pal_we, pal_re;
   logic [SLOT_W-1:0] pal_waddr, pal_raddr;

   // request fields and locate
   logic [ACT_W-1:0]  req_action;
   logic [POS_W-1:0]  req_x, req_y, req_z;
   id_type            req_id;
   logic              req_acc;
   coord_type         nx, ny, nz;
   logic [FACE_W-1:0] loc_face;
   logic              in_grid;
   logic [ADDR_W-1:0] loc_cell;
   id_type            cur_id;
   logic              rsp_load;
   logic              face_done;

   assign req_action = req_tuser[ACT_W-1:0];
   assign req_x      = req_tdata[X_LSB +: POS_W];
   assign req_y      = req_tdata[Y_LSB +: POS_W];
   assign req_z      = req_tdata[Z_LSB +: POS_W];
   assign req_id     = req_tdata[ID_LSB +: ID_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      if (state_ff == ST_IDLE) begin
         nx       = coord_type'(req_x);
         ny       = coord_type'(req_y);
         nz       = coord_type'(req_z);
         loc_face = FACE_SELF;
      end else begin
         nx       = coord_type'(x_ff);
         ny       = coord_type'(y_ff);
         nz       = coord_type'(z_ff);
         loc_face = face_ff;
      end
      case (loc_face)
         FACE_LEFT:   nx = nx - coord_type'(1);
         FACE_RIGHT:  nx = nx + coord_type'(1);
         FACE_FRONT:  nz = nz + coord_type'(1);
         FACE_BACK:   nz = nz - coord_type'(1);
         FACE_TOP:    ny = ny + coord_type'(1);
         FACE_BOTTOM: ny = ny - coord_type'(1);
         default: ;
      endcase
      in_grid  = (nx >= 0) && (ny >= 0) && (nz >= 0) &&
                 (nx < EDGE_C) && (ny < HEIGHT_C) && (nz < EDGE_C);
      loc_cell = ADDR_W'(nx) + ADDR_W'(ny) * ROW_STEP + ADDR_W'(nz) * SLICE_STEP;
   end

   assign cur_id    = (rd_slot_ff == '0) ? slot0_ff : pal_q_ff;
   assign face_done = (face_ff == FACE_SELF) || (face_ff == FACE_BOTTOM);

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      cnt_in        = cnt_ff;
      rd_slot_in    = rd_slot_ff;
      rd_vld_in     = rd_vld_ff;
      sweep_in      = sweep_ff;
      clear_pend_in = clear_pend_ff;
      face_in       = face_ff;
      slot0_in      = slot0_ff;
      cell_in       = cell_ff;
      res_id_in     = res_id_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      use_pal_in    = use_pal_ff;
      rsp_load      = 1'b0;
      vox_we        = 1'b0;
      vox_waddr     = cell_ff;
      vox_wdata     = '0;
      vox_re        = 1'b0;
      vox_raddr     = loc_cell;
      pal_we        = 1'b0;
      pal_waddr     = SLOT_W'(used_ff);
      pal_re        = 1'b0;
      pal_raddr     = SLOT_W'(cnt_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               face_in    = FACE_SELF;
               use_pal_in = 1'b0;
               unique case (req_action)
                  ACT_WRITE: begin
                     if (!in_grid) begin
                        res_id_in     = '0;
                        res_slot_in   = '0;
                        res_status_in = STATUS_OUT_OF_GRID;
                        state_in      = ST_EMIT;
                     end else begin
                        cell_in    = loc_cell;
                        cnt_in     = CNT_W'(1);
                        rd_slot_in = '0;
                        rd_vld_in  = 1'b1;
                        state_in   = ST_SEARCH;
                     end
                  end
                  ACT_READ: begin
                     state_in = ST_RD_VOX;
                  end
                  ACT_NEIGHBORS: begin
                     face_in  = FACE_LEFT;
                     state_in = ST_RD_VOX;
                  end
                  ACT_CLEAR: begin
                     slot0_in      = filler_ff;
                     used_in       = CNT_W'(1);
                     sweep_in      = '0;
                     clear_pend_in = 1'b1;
                     state_in      = ST_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            if (rd_vld_ff && cur_id == id_ff) begin
               vox_we        = 1'b1;
               vox_wdata     = SLOT_W'(rd_slot_ff);
               res_id_in     = id_ff;
               res_slot_in   = SLOT_W'(rd_slot_ff);
               res_status_in = STATUS_OK;
               state_in      = ST_EMIT;
            end else if (!rd_vld_ff) begin
               state_in = ST_EMIT;
               if (used_ff == FULL_CNT) begin
                  res_id_in     = '0;
                  res_slot_in   = '0;
                  res_status_in = STATUS_FULL;
               end else begin
                  pal_we        = 1'b1;
                  used_in       = used_ff + 1'b1;
                  vox_we        = 1'b1;
                  vox_wdata     = SLOT_W'(used_ff);
                  res_id_in     = id_ff;
                  res_slot_in   = SLOT_W'(used_ff);
                  res_status_in = STATUS_OK;
               end
            end else begin
               pal_re     = (cnt_ff < used_ff);
               rd_slot_in = cnt_ff;
               rd_vld_in  = (cnt_ff < used_ff);
               if (cnt_ff < used_ff) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_RD_VOX: begin
            if (!in_grid) begin
               res_id_in     = '0;
               res_slot_in   = '0;
               res_status_in = STATUS_OUT_OF_GRID;
               use_pal_in    = 1'b0;
               state_in      = ST_EMIT;
            end else begin
               vox_re   = 1'b1;
               state_in = ST_RD_PAL;
            end
         end
         ST_RD_PAL: begin
            res_slot_in   = vox_q_ff;
            res_id_in     = slot0_ff;
            res_status_in = STATUS_OK;
            use_pal_in    = (vox_q_ff != '0);
            pal_re        = (vox_q_ff != '0);
            pal_raddr     = vox_q_ff;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               if (face_done) begin
                  state_in = ST_IDLE;
               end else begin
                  face_in  = FACE_W'(face_ff + 1'b1);
                  state_in = ST_RD_VOX;
               end
            end
         end
         ST_SWEEP: begin
            vox_we    = 1'b1;
            vox_waddr = sweep_ff;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               if (clear_pend_ff) begin
                  clear_pend_in = 1'b0;
                  res_id_in     = '0;
                  res_slot_in   = '0;
                  res_status_in = STATUS_OK;
                  use_pal_in    = 1'b0;
                  state_in      = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         used_ff       <= CNT_W'(1);
         cnt_ff        <= '0;
         rd_slot_ff    <= '0;
         rd_vld_ff     <= 1'b0;
         sweep_ff      <= '0;
         clear_pend_ff <= 1'b0;
         face_ff       <= FACE_SELF;
         rsp_valid_ff  <= 1'b0;
         filler_ff     <= '0;
         slot0_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         cnt_ff        <= cnt_in;
         rd_slot_ff    <= rd_slot_in;
         rd_vld_ff     <= rd_vld_in;
         sweep_ff      <= sweep_in;
         clear_pend_ff <= clear_pend_in;
         face_ff       <= face_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot0_ff      <= slot0_in;
         if (csr_wr_en) begin
            filler_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff       <= cell_in;
      res_id_ff     <= res_id_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      use_pal_ff    <= use_pal_in;
      if (req_acc) begin
         x_ff  <= req_x;
         y_ff  <= req_y;
         z_ff  <= req_z;
         id_ff <= req_id;
      end
      if (rsp_load) begin
         rsp_id_ff     <= use_pal_ff ? pal_q_ff : res_id_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_face_ff   <= face_ff;
         rsp_status_ff <= res_status_ff;
         rsp_last_ff   <= face_done;
      end
   end

   always_ff @(posedge clock) begin
      if (vox_we) begin
         vox_mem[vox_waddr] <= vox_wdata;
      end
      if (vox_re) begin
         vox_q_ff <= vox_mem[vox_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_waddr] <= id_ff;
      end
      if (pal_re) begin
         pal_q_ff <= pal_mem[pal_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FILL_W){1'b0}}, SLOT_OUT_W'(rsp_slot_ff), rsp_id_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_face_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      (used_ff >= CNT_W'(1)) && (used_ff <= FULL_CNT))
      else $error("palette fill count out of range");

   a_clear_restart: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_action == ACT_CLEAR |=> state_ff == ST_SWEEP && used_ff == CNT_W'(1))
      else $error("clear did not restart the palette and sweep");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      pal_we |=> used_ff == $past(used_ff) + 1'b1)
      else $error("palette append did not advance fill count");

   a_slot_in_use: assert property (@(posedge clock) disable iff (reset)
      vox_we |-> (CNT_W'(vox_wdata) < used_ff) || (pal_we && CNT_W'(vox_wdata) == used_ff))
      else $error("voxel written with a slot not in use");

   a_last_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_face_ff == FACE_SELF || rsp_face_ff == FACE_BOTTOM)
      else $error("last response on an inner face");
`endif

endmodule
